// ----- hdl/evas_pkg.sv -----
// ----------------------------------------------------------------------------
// evas_pkg
// shared types and constants of the energy voice activity segmenter
// ----------------------------------------------------------------------------
`default_nettype none

package evas_pkg;

  // sizing
  localparam int unsigned MaxSegmentSamples = 524288;
  localparam int unsigned MaxFrameSamples   = 4096;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned MagW     = SampleW + 1;
  localparam int unsigned EnergyW  = 40;
  localparam int unsigned CountW   = 8;
  localparam int unsigned SegW     = 20;
  localparam int unsigned FrameW   = $clog2(MaxFrameSamples + 1);

  // configuration port
  localparam int unsigned DataW    = 64;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned RegIdxW  = 2;

  typedef logic [RegIdxW-1:0] reg_idx_t;
  localparam reg_idx_t RegNoiseThreshold = 2'd0;
  localparam reg_idx_t RegStartFrames    = 2'd1;
  localparam reg_idx_t RegEndFrames      = 2'd2;

  localparam logic [EnergyW-1:0] NoiseThresholdRst = 40'd150000;
  localparam logic [CountW-1:0]  StartFramesRst    = 8'd5;
  localparam logic [CountW-1:0]  EndFramesRst      = 8'd20;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_SPEAK = 2'd2,
    PH_END   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ACT_IGNORE  = 2'd0,
    ACT_KEEP    = 2'd1,
    ACT_DISCARD = 2'd2,
    ACT_DONE    = 2'd3
  } action_e;

endpackage

`default_nettype wire

// ----- hdl/energy_voice_activity_segmenter.sv -----
// ----------------------------------------------------------------------------
// energy_voice_activity_segmenter
// frame energy voice activity detector with start confirmation and hangover
// ----------------------------------------------------------------------------
// path: a frame-end beat is held in the stage 1 sample register and loads the
//   result register once that register is free, which then offers its result beat
// throughput: one sample beat per cycle, set by the single accumulate and
//   phase update stage; a frame-end beat waiting on a held result blocks input
// reset: asynchronous, active low; phase idle, all counts and sums zero,
//   registers at their defaults, no beat pending on either side
`default_nettype none

module energy_voice_activity_segmenter
  import evas_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // sample channel
  input  wire logic                sample_valid_i,
  output logic                     sample_ready_o,
  input  wire logic signed [15:0]  sample_i,
  input  wire logic                frame_end_i,

  // result channel
  output logic                     result_valid_o,
  input  wire logic                result_ready_i,
  output logic [1:0]               action_o,
  output logic [1:0]               phase_after_o,
  output logic [19:0]              segment_samples_o,
  output logic                     overflow_o,

  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrW-1:0]    paddr,
  input  wire logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [EnergyW-1:0] noise_threshold_q;
  logic [CountW-1:0]  start_frames_q;
  logic [CountW-1:0]  end_frames_q;
  reg_idx_t           cfg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[AddrW-1:AddrW-RegIdxW];  // registers sit on 8-byte steps
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_threshold_q <= NoiseThresholdRst;
      start_frames_q    <= StartFramesRst;
      end_frames_q      <= EndFramesRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegNoiseThreshold: noise_threshold_q <= pwdata[EnergyW-1:0];
        RegStartFrames:    start_frames_q    <= pwdata[CountW-1:0];
        RegEndFrames:      end_frames_q      <= pwdata[CountW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegNoiseThreshold: prdata = {{(DataW-EnergyW){1'b0}}, noise_threshold_q};
      RegStartFrames:    prdata = {{(DataW-CountW){1'b0}}, start_frames_q};
      RegEndFrames:      prdata = {{(DataW-CountW){1'b0}}, end_frames_q};
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // stage 1: sample register, holds the magnitude and the frame-end mark
  // --------------------------------------------------------------------------
  logic            s1_valid_q;
  logic [MagW-1:0] s1_mag_q;
  logic            s1_frame_end_q;
  logic [MagW-1:0] mag;
  logic            in_beat;
  logic            out_free;
  logic            s1_adv;
  logic            out_load;

  // two's complement magnitude; the most negative sample gives 32768
  assign mag = sample_i[15] ? (MagW'(0) - {sample_i[15], sample_i})
                            : {1'b0, sample_i};

  // the result register is free if empty or being drained this cycle
  assign out_free = !result_valid_o || result_ready_i;
  // plain samples never wait; a frame end needs room in the result register
  assign s1_adv   = s1_valid_q && (!s1_frame_end_q || out_free);
  assign out_load = s1_adv && s1_frame_end_q;

  assign sample_ready_o = !s1_valid_q || s1_adv;
  assign in_beat        = sample_valid_i && sample_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_ready_o) begin
      s1_valid_q <= sample_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_mag_q       <= mag;
      s1_frame_end_q <= frame_end_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: frame accumulation and segment phase machine
  // --------------------------------------------------------------------------
  phase_e             phase_q, phase_d;
  logic [CountW-1:0]  start_count_q, start_count_d;
  logic [CountW-1:0]  end_count_q, end_count_d;
  logic [EnergyW-1:0] energy_q, energy_d;
  logic [FrameW-1:0]  frame_q, frame_d;
  logic [SegW-1:0]    seg_len_q, seg_len_d;
  logic               ovf_q, ovf_d;

  logic [EnergyW:0]   energy_sum;
  logic [EnergyW-1:0] energy_sat;
  logic [FrameW-1:0]  frame_inc;
  logic [SegW:0]      seg_sum;
  logic               seg_over;
  logic [SegW-1:0]    seg_add_len;
  logic               seg_add_ovf;
  logic               loud;
  logic [CountW-1:0]  start_inc;
  logic [CountW-1:0]  end_inc;
  action_e            act;
  logic [SegW-1:0]    rep_len;
  logic               rep_ovf;

  // energy saturates at the all-ones value
  assign energy_sum = {1'b0, energy_q} + (EnergyW+1)'(s1_mag_q);
  assign energy_sat = energy_sum[EnergyW] ? '1 : energy_sum[EnergyW-1:0];

  // frame length saturates at the frame capacity
  assign frame_inc  = (frame_q < FrameW'(MaxFrameSamples)) ? frame_q + FrameW'(1) : frame_q;

  // segment length with this frame added, saturating at capacity
  assign seg_sum     = {1'b0, seg_len_q} + (SegW+1)'(frame_inc);
  assign seg_over    = seg_sum > (SegW+1)'(MaxSegmentSamples);
  assign seg_add_len = seg_over ? SegW'(MaxSegmentSamples) : seg_sum[SegW-1:0];
  assign seg_add_ovf = ovf_q || seg_over;

  assign loud      = energy_sat >= noise_threshold_q;
  assign start_inc = (start_count_q != '1) ? start_count_q + CountW'(1) : start_count_q;
  assign end_inc   = (end_count_q != '1) ? end_count_q + CountW'(1) : end_count_q;

  always_comb begin
    phase_d       = phase_q;
    start_count_d = start_count_q;
    end_count_d   = end_count_q;
    energy_d      = energy_q;
    frame_d       = frame_q;
    seg_len_d     = seg_len_q;
    ovf_d         = ovf_q;
    act           = ACT_KEEP;
    rep_len       = '0;
    rep_ovf       = 1'b0;

    if (s1_adv) begin
      if (!s1_frame_end_q) begin
        energy_d = energy_sat;
        frame_d  = frame_inc;
      end else begin
        // frame closes: next frame starts from zero
        energy_d = '0;
        frame_d  = '0;

        if (loud) begin
          seg_len_d = seg_add_len;
          ovf_d     = seg_add_ovf;
          unique case (phase_q)
            PH_IDLE: begin
              phase_d       = PH_START;
              start_count_d = start_inc;
            end
            PH_START: begin
              start_count_d = start_inc;
              if (start_inc > start_frames_q) phase_d = PH_SPEAK;
            end
            PH_SPEAK: ;
            PH_END: begin
              // loud frame cancels one quiet frame of hangover
              if (end_count_q <= CountW'(1)) begin
                end_count_d = '0;
                phase_d     = PH_SPEAK;
              end else begin
                end_count_d = end_count_q - CountW'(1);
              end
            end
            default: ;
          endcase
        end else begin
          unique case (phase_q)
            PH_IDLE: act = ACT_IGNORE;
            PH_START: begin
              // burst too short, drop it
              act           = ACT_DISCARD;
              phase_d       = PH_IDLE;
              start_count_d = '0;
              end_count_d   = '0;
              seg_len_d     = '0;
              ovf_d         = 1'b0;
            end
            PH_SPEAK: begin
              seg_len_d   = seg_add_len;
              ovf_d       = seg_add_ovf;
              phase_d     = PH_END;
              end_count_d = end_inc;
            end
            PH_END: begin
              seg_len_d   = seg_add_len;
              ovf_d       = seg_add_ovf;
              end_count_d = end_inc;
              if (end_inc > end_frames_q) act = ACT_DONE;
            end
            default: ;
          endcase
        end

        // report what the segment holds after this frame
        if (act == ACT_KEEP || act == ACT_DONE) begin
          rep_len = seg_len_d;
          rep_ovf = ovf_d;
        end

        // hangover expired: segment complete, start over
        if (act == ACT_DONE) begin
          phase_d       = PH_IDLE;
          start_count_d = '0;
          end_count_d   = '0;
          seg_len_d     = '0;
          ovf_d         = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      start_count_q <= '0;
      end_count_q   <= '0;
      energy_q      <= '0;
      frame_q       <= '0;
      seg_len_q     <= '0;
      ovf_q         <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      start_count_q <= start_count_d;
      end_count_q   <= end_count_d;
      energy_q      <= energy_d;
      frame_q       <= frame_d;
      seg_len_q     <= seg_len_d;
      ovf_q         <= ovf_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else if (out_load) begin
      result_valid_o <= 1'b1;
    end else if (result_ready_i) begin
      result_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      action_o          <= act;
      phase_after_o     <= phase_d;
      segment_samples_o <= rep_len;
      overflow_o        <= rep_ovf;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_energy_voice_activity_segmenter.sv -----
// ----------------------------------------------------------------------------
// tb_energy_voice_activity_segmenter
// self-checking bench: sample beats in, one frame verdict per frame-end beat
// out, each verdict checked field by field against an in-bench phase predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_energy_voice_activity_segmenter;
  import evas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run control
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdlePct    = 32;
  localparam int unsigned SettleGap  = 4;

  typedef logic [EnergyW:0] energy_acc_t;
  typedef logic [SegW:0]    seg_acc_t;

  // one expected verdict per frame-end beat
  typedef struct packed {
    action_e           act;
    phase_e            ph;
    logic [SegW-1:0]   len;
    logic              ovf;
  } frame_verdict_t;

  // dut ports
  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        sample_valid_i = 1'b0;
  logic                        sample_ready_o;
  logic signed [SampleW-1:0]   sample_i       = '0;
  logic                        frame_end_i    = 1'b0;
  logic                        result_valid_o;
  logic                        result_ready_i = 1'b0;
  logic [1:0]                  action_o;
  logic [1:0]                  phase_after_o;
  logic [SegW-1:0]             segment_samples_o;
  logic                        overflow_o;
  logic                        psel           = 1'b0;
  logic                        penable        = 1'b0;
  logic                        pwrite         = 1'b0;
  logic [AddrW-1:0]            paddr          = '0;
  logic [DataW-1:0]            pwdata         = '0;
  logic [DataW-1:0]            prdata;
  logic                        pready;

  // predictor copy of the configuration
  logic [EnergyW-1:0]          cfg_threshold  = NoiseThresholdRst;
  logic [CountW-1:0]           cfg_start_lim  = StartFramesRst;
  logic [CountW-1:0]           cfg_end_lim    = EndFramesRst;

  // predictor copy of the detector state
  phase_e                      vad_phase      = PH_IDLE;
  logic [CountW-1:0]           loud_run       = '0;
  logic [CountW-1:0]           quiet_run      = '0;
  logic [EnergyW-1:0]          frame_energy   = '0;
  logic [FrameW-1:0]           frame_fill     = '0;
  logic [SegW-1:0]             seg_len        = '0;
  logic                        seg_ovf        = 1'b0;

  frame_verdict_t              frame_verdicts[$];

  int unsigned                 errors         = 0;
  int unsigned                 cycle_count    = 0;
  bit                          no_idle        = 1'b0;
  bit                          hold_on        = 1'b0;

  energy_voice_activity_segmenter DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_valid_i    (sample_valid_i),
    .sample_ready_o    (sample_ready_o),
    .sample_i          (sample_i),
    .frame_end_i       (frame_end_i),
    .result_valid_o    (result_valid_o),
    .result_ready_i    (result_ready_i),
    .action_o          (action_o),
    .phase_after_o     (phase_after_o),
    .segment_samples_o (segment_samples_o),
    .overflow_o        (overflow_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // add the finished frame to the open segment, saturating at capacity
  function automatic void grow_segment();
    seg_acc_t total;
    total = seg_acc_t'(seg_len) + seg_acc_t'(frame_fill);
    if (total > seg_acc_t'(MaxSegmentSamples)) begin
      total   = seg_acc_t'(MaxSegmentSamples);
      seg_ovf = 1'b1;
    end
    seg_len = total[SegW-1:0];
  endfunction

  function automatic void close_segment();
    vad_phase = PH_IDLE;
    loud_run  = '0;
    quiet_run = '0;
    seg_len   = '0;
    seg_ovf   = 1'b0;
  endfunction

  // fold one accepted sample beat into the state; a frame end yields a verdict
  function automatic void predict_sample(input logic signed [SampleW-1:0] s,
                                         input logic fe);
    logic [MagW-1:0] mag;
    energy_acc_t     acc;
    logic            loud;
    action_e         act;
    frame_verdict_t  v;
    // magnitude in 17 bits so that -32768 gives 32768
    mag = {s[SampleW-1], s};
    if (s[SampleW-1]) mag = -mag;
    acc = energy_acc_t'(frame_energy) + energy_acc_t'(mag);
    if (acc[EnergyW]) frame_energy = '1;
    else frame_energy = acc[EnergyW-1:0];
    // overlong frames stop counting samples but keep adding energy
    if (frame_fill < MaxFrameSamples) frame_fill++;
    if (!fe) return;

    loud = (frame_energy >= cfg_threshold);
    act  = ACT_KEEP;
    if (loud) begin
      grow_segment();
      case (vad_phase)
        PH_IDLE: begin
          vad_phase = PH_START;
          if (loud_run != '1) loud_run++;
        end
        PH_START: begin
          if (loud_run != '1) loud_run++;
          if (loud_run > cfg_start_lim) vad_phase = PH_SPEAK;
        end
        PH_END: begin
          // hangover is paid back one frame at a time, clamped at zero
          if (quiet_run <= 1) begin
            quiet_run = '0;
            vad_phase = PH_SPEAK;
          end else begin
            quiet_run--;
          end
        end
        default: ;
      endcase
    end else begin
      case (vad_phase)
        PH_IDLE: act = ACT_IGNORE;
        PH_START: begin
          close_segment();
          act = ACT_DISCARD;
        end
        PH_SPEAK: begin
          // first quiet frame never checks the end limit
          grow_segment();
          vad_phase = PH_END;
          if (quiet_run != '1) quiet_run++;
        end
        default: begin
          grow_segment();
          if (quiet_run != '1) quiet_run++;
          if (quiet_run > cfg_end_lim) act = ACT_DONE;
        end
      endcase
    end

    v.act = act;
    v.len = seg_len;
    v.ovf = seg_ovf;
    if (act == ACT_DONE) close_segment();
    if (act == ACT_IGNORE || act == ACT_DISCARD) begin
      v.len = '0;
      v.ovf = 1'b0;
    end
    v.ph = vad_phase;
    frame_energy = '0;
    frame_fill   = '0;
    frame_verdicts.push_back(v);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random backpressure plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_count;
    hold_count = 0;
    forever begin
      @(posedge clk_i);
      if (hold_on && hold_count < HoldCycles) begin
        // hold-off counted here so the sender keeps pushing beats meanwhile
        hold_count++;
        result_ready_i <= 1'b0;
      end else begin
        if (!hold_on) hold_count = 0;
        result_ready_i <= no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // every accepted result beat is matched against the oldest verdict
  always @(posedge clk_i) begin
    frame_verdict_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (frame_verdicts.size() == 0) begin
        $error("result beat with no frame verdict pending");
        errors++;
      end else begin
        want = frame_verdicts.pop_front();
        if (action_o !== want.act) begin
          $error("action: expected %0d, actual %0d", want.act, action_o);
          errors++;
        end
        if (phase_after_o !== want.ph) begin
          $error("phase_after: expected %0d, actual %0d", want.ph, phase_after_o);
          errors++;
        end
        if (segment_samples_o !== want.len) begin
          $error("segment_samples: expected %0d, actual %0d", want.len,
                 segment_samples_o);
          errors++;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow: expected %0d, actual %0d", want.ovf, overflow_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sample side and configuration
  // ---------------------------------------------------------------------------

  // offer one sample beat, with random idle cycles in front of it
  task automatic send_beat(input logic signed [SampleW-1:0] s, input logic fe);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    frame_end_i    <= fe;
    do @(posedge clk_i); while (!sample_ready_o);
    predict_sample(s, fe);
  endtask

  // one frame of len beats; loud frames carry big or fully random samples
  task automatic send_frame(input int unsigned len, input bit loud);
    logic signed [SampleW-1:0] s;
    for (int unsigned i = 0; i < len; i++) begin
      if (!loud) begin
        s = SampleW'($urandom_range(127)) - 16'sd64;
      end else if ($urandom_range(1) != 0) begin
        s = SampleW'($urandom());
      end else begin
        s = SampleW'($urandom_range(32767, 16384));
        if ($urandom_range(1) != 0) s = -s;
      end
      send_beat(s, i == len - 1);
    end
  endtask

  // stop offering beats until every verdict is back and the pipe is empty
  task automatic settle();
    sample_valid_i <= 1'b0;
    while (frame_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  // setup phase and access phase, then the bus goes idle
  task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegNoiseThreshold: cfg_threshold = value[EnergyW-1:0];
      RegStartFrames:    cfg_start_lim = value[CountW-1:0];
      RegEndFrames:      cfg_end_lim   = value[CountW-1:0];
      default: ;
    endcase
  endtask

  // all three registers, with junk above each field to exercise masking
  task automatic configure(input logic [EnergyW-1:0] thr,
                           input logic [CountW-1:0] start_lim,
                           input logic [CountW-1:0] end_lim);
    logic [DataW-1:0] raw;
    settle();
    raw = {$urandom(), $urandom()};
    raw[EnergyW-1:0] = thr;
    write_reg(RegNoiseThreshold, raw);
    raw = {$urandom(), $urandom()};
    raw[CountW-1:0] = start_lim;
    write_reg(RegStartFrames, raw);
    raw = {$urandom(), $urandom()};
    raw[CountW-1:0] = end_lim;
    write_reg(RegEndFrames, raw);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // walk every phase and action with hand-picked frames of one or two samples
  task automatic test_phase_walk();
    configure(40'd40000, 8'd1, 8'd1);
    send_beat(16'sd0, 1'b0);       send_beat(-16'sd1, 1'b1);      // quiet in idle
    send_beat(16'sd32767, 1'b0);   send_beat(-16'sd32768, 1'b1);  // idle to starting
    send_beat(16'sd19999, 1'b0);   send_beat(-16'sd20000, 1'b1);  // one below: discard
    send_beat(16'sd20000, 1'b0);   send_beat(-16'sd20000, 1'b1);  // equal counts as loud
    send_beat(-16'sd32768, 1'b0);  send_beat(16'sd32767, 1'b1);   // speech confirmed
    send_beat(-16'sd32768, 1'b1);                                 // quiet: ending
    send_beat(16'sd30000, 1'b0);   send_beat(16'sd30000, 1'b1);   // loud: back to speaking
    send_beat(16'sd1, 1'b1);       send_beat(16'sd0, 1'b1);       // hangover runs out
    send_beat(16'sd0, 1'b1);                                      // idle again
  endtask

  // threshold and count limits at both ends, counters driven into saturation
  task automatic test_register_extremes();
    configure('1, 8'd0, 8'd0);
    send_beat(-16'sd32768, 1'b0);
    send_beat(16'sd32767, 1'b0);
    send_beat(-16'sd32768, 1'b1);
    // zero threshold: even a silent frame is loud
    configure('0, 8'd0, 8'd0);
    send_beat(16'sd0, 1'b1);
    send_beat(16'sd0, 1'b1);
    configure(40'd1, 8'd0, 8'd0);
    send_beat(16'sd0, 1'b1);
    send_beat(16'sd0, 1'b1);
    // start count pinned at 255 never passes a limit of 255
    configure(40'd1, 8'd255, 8'd255);
    repeat (257) send_beat(16'sd7, 1'b1);
    send_beat(16'sd0, 1'b1);
    // end count pinned at 255 likewise never completes
    configure(40'd1, 8'd0, 8'd255);
    send_beat(16'sd7, 1'b1);
    send_beat(16'sd7, 1'b1);
    repeat (257) send_beat(16'sd0, 1'b1);
    // lowering the limit mid-segment lets the next quiet frame finish it
    configure(40'd1, 8'd0, 8'd254);
    send_beat(16'sd0, 1'b1);
  endtask

  // long frames back to back, no idling on either side
  task automatic test_long_frames();
    configure(40'd1, 8'd0, 8'd0);
    no_idle = 1'b1;
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < 30; i++) send_beat(SampleW'($urandom()), 1'b0);
      send_beat(16'sd100, 1'b1);
    end
    // hangover, completed segment, then a lone burst that is discarded
    send_beat(16'sd0, 1'b1);
    send_beat(16'sd0, 1'b1);
    send_beat(16'sd100, 1'b1);
    send_beat(16'sd0, 1'b1);
    settle();
    no_idle = 1'b0;
  endtask

  // random frames over several settings, with a long result hold-off
  task automatic test_random_traffic();
    int unsigned budget;
    int unsigned min_len;
    int unsigned max_len;
    int unsigned loud_pct;
    int unsigned sent;
    int unsigned len;
    for (int step = 0; step < 5; step++) begin
      case (step)
        0: begin
          configure(NoiseThresholdRst, StartFramesRst, EndFramesRst);
          budget = 120; min_len = 5; max_len = 12; loud_pct = 70;
        end
        1: begin
          configure(EnergyW'($urandom_range(100000, 20000)),
                    CountW'($urandom_range(3)), CountW'($urandom_range(3)));
          budget = 150; min_len = 1; max_len = 6; loud_pct = 55;
          hold_on = 1'b1;
        end
        2: begin
          configure(EnergyW'({$urandom(), $urandom()}),
                    CountW'($urandom()), CountW'($urandom()));
          budget = 40; min_len = 1; max_len = 4; loud_pct = 50;
        end
        3: begin
          configure('0, 8'd255, 8'd0);
          budget = 60; min_len = 1; max_len = 3; loud_pct = 50;
          no_idle = 1'b1;
        end
        default: begin
          configure(EnergyW'($urandom_range(60000, 5000)),
                    CountW'($urandom_range(6)), CountW'($urandom_range(6)));
          budget = 160; min_len = 1; max_len = 5; loud_pct = 55;
        end
      endcase
      sent = 0;
      while (sent < budget) begin
        len = $urandom_range(max_len, min_len);
        send_frame(len, $urandom_range(99) < loud_pct);
        sent += len;
        if (sent > 100) hold_on = 1'b0;
        // mid-run pause: let every verdict drain before carrying on
        if (step == 4 && sent >= 80 && sent < 80 + max_len) settle();
      end
      hold_on = 1'b0;
      no_idle = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_phase_walk();
    test_register_extremes();
    test_long_frames();
    test_random_traffic();

    // drain, then wait on so that a stray beat would still show up
    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
